>>> design/weighted_healthy_backend_picker_macros.svh
// Assertion helpers for the picker design file.
`ifndef WEIGHTED_HEALTHY_BACKEND_PICKER_MACROS_SVH
`define WEIGHTED_HEALTHY_BACKEND_PICKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WHBP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define WHBP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/whbp_pkg.sv
package whbp_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int WEIGHT_BITS = 16;

  localparam int IDX_W    = $clog2(MAX_ENTRIES);
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int ID_W     = 16;
  localparam int FIELD_W  = 16;
  localparam int DRAW_W   = 16;
  localparam int HEALTH_W = 16;
  localparam int CUR_W    = 5;
  localparam int SLOT_W   = 4;
  localparam int SUM_W    = 20;
  localparam int TOT_W    = WEIGHT_BITS + CNT_W;
  localparam int PROD_W   = DRAW_W + TOT_W;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_PICK   = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NULL   = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_ABSENT = 2'd3;

  typedef struct packed {
    logic [1:0]          operation;
    logic [ID_W-1:0]     target_id;
    logic [FIELD_W-1:0]  entry_weight;
    logic [DRAW_W-1:0]   draw;
    logic [HEALTH_W-1:0] health_mask;
    logic [CUR_W-1:0]    cursor_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   picked_id;
    logic [SLOT_W-1:0] picked_slot;
    logic [CUR_W-1:0]  cursor_out;
    logic [CUR_W-1:0]  entry_total;
    logic [SUM_W-1:0]  sum_of_weights;
  } out_item_t;

  // Slots beyond the mask width have no health bit and count as unhealthy.
  function automatic logic slot_healthy(input logic [HEALTH_W-1:0] mask,
                                        input logic [CNT_W-1:0] idx);
    logic [31:0] ext;
    ext = 32'(idx);
    return (ext < 32'(HEALTH_W)) && mask[ext[$clog2(HEALTH_W)-1:0]];
  endfunction

endpackage

>>> design/whbp_in_if.sv
interface whbp_in_if;
  logic                valid;
  logic                ready;
  whbp_pkg::in_item_t  data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/whbp_out_if.sv
interface whbp_out_if;
  logic                valid;
  logic                ready;
  whbp_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> design/weighted_healthy_backend_picker.sv
// Weighted healthy backend picker. The block holds a compact table of up to
// MAX_ENTRIES target ids with integer weights and a 20-bit running total, and
// serves one operation per transfer: add appends an entry, remove deletes the
// first entry with a matching id, closes the gap and adjusts the caller's
// round-robin cursor, and pick returns the first healthy slot whose running
// healthy weight exceeds (draw * healthy_sum) >> 16. Items are processed one
// at a time by a small sequencer that walks the table one slot per cycle
// through a single shared adder and comparator. Add, a remove with the null
// id and unknown operations go straight to the output state. Remove first
// scans up to the matching slot and then moves each later entry down one
// slot; a miss scans the whole table. Pick makes a pass to total the healthy
// weights, a multiply step, a second pass that stops at the chosen slot, and
// the output state; with no healthy weight it ends after the first pass. The
// input is not ready while an item is in progress, but a finished result
// sits in an output register so the next item can be transferred while it
// waits to be taken.
`include "weighted_healthy_backend_picker_macros.svh"

module weighted_healthy_backend_picker (
  input  logic                clk,
  input  logic                rst_n,
  whbp_in_if.sink             in_ch,
  whbp_out_if.source          out_ch
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FIND  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SEL   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // Entry table. Only values from slots below the entry count are ever used.
  logic [whbp_pkg::ID_W-1:0]        id_mem_r [whbp_pkg::MAX_ENTRIES];
  logic [whbp_pkg::WEIGHT_BITS-1:0] wt_mem_r [whbp_pkg::MAX_ENTRIES];

  logic [2:0]                     state_r, state_nxt;
  logic [whbp_pkg::CNT_W-1:0]     used_r, used_nxt;
  logic [whbp_pkg::SUM_W-1:0]     wsum_r, wsum_nxt;
  logic [whbp_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [whbp_pkg::IDX_W-1:0]     found_r, found_nxt;
  logic [whbp_pkg::TOT_W-1:0]     acc_r, acc_nxt;
  logic [whbp_pkg::TOT_W-1:0]     tot_r, tot_nxt;
  logic [whbp_pkg::TOT_W-1:0]     target_r, target_nxt;
  logic [whbp_pkg::ID_W-1:0]      id_r, id_nxt;
  logic [whbp_pkg::DRAW_W-1:0]    draw_r, draw_nxt;
  logic [whbp_pkg::HEALTH_W-1:0]  mask_r, mask_nxt;
  logic [whbp_pkg::CUR_W-1:0]     cur_r, cur_nxt;
  logic [1:0]                     status_r, status_nxt;
  logic [whbp_pkg::ID_W-1:0]      pid_r, pid_nxt;
  logic [whbp_pkg::SLOT_W-1:0]    pslot_r, pslot_nxt;
  logic                           out_valid_r, out_valid_nxt;
  whbp_pkg::out_item_t            out_data_r, out_data_nxt;

  // Table write port.
  logic                             wr_en;
  logic [whbp_pkg::IDX_W-1:0]       wr_idx;
  logic [whbp_pkg::ID_W-1:0]        wr_id;
  logic [whbp_pkg::WEIGHT_BITS-1:0] wr_wt;

  // Single read port: the shift pass reads one slot ahead of the write.
  logic [whbp_pkg::IDX_W-1:0]       rd_idx;
  logic [whbp_pkg::ID_W-1:0]        rd_id;
  logic [whbp_pkg::WEIGHT_BITS-1:0] rd_wt;

  // Shared accumulator adder and the multiplier for the target.
  logic [whbp_pkg::TOT_W-1:0]  add_res;
  logic [whbp_pkg::PROD_W-1:0] prod;
  logic                        healthy;
  logic                        in_xfer;
  logic [whbp_pkg::CUR_W-1:0]  cur_adj;
  logic [whbp_pkg::CNT_W-1:0]  n_after;

  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign rd_idx  = (state_r == S_SHIFT) ? whbp_pkg::IDX_W'(idx_r + 1'b1)
                                        : idx_r[whbp_pkg::IDX_W-1:0];
  assign rd_id   = id_mem_r[rd_idx];
  assign rd_wt   = wt_mem_r[rd_idx];
  assign add_res = acc_r + whbp_pkg::TOT_W'(rd_wt);
  assign healthy = whbp_pkg::slot_healthy(mask_r, idx_r);
  assign prod    = whbp_pkg::PROD_W'(draw_r) * whbp_pkg::PROD_W'(tot_r);
  assign n_after = used_r - 1'b1;

  // Cursor fix-up after a remove: a cursor past the removed slot steps
  // back, one sitting at the new end wraps, and one beyond the end resets.
  always_comb begin
    cur_adj = cur_r;
    if (int'(found_r) < int'(cur_r)) begin
      cur_adj = cur_r - 1'b1;
    end else if (int'(cur_r) == int'(n_after)) begin
      cur_adj = '0;
    end
    if (int'(cur_adj) > int'(n_after)) begin
      cur_adj = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    wsum_nxt      = wsum_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    acc_nxt       = acc_r;
    tot_nxt       = tot_r;
    target_nxt    = target_r;
    id_nxt        = id_r;
    draw_nxt      = draw_r;
    mask_nxt      = mask_r;
    cur_nxt       = cur_r;
    status_nxt    = status_r;
    pid_nxt       = pid_r;
    pslot_nxt     = pslot_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_idx        = idx_r[whbp_pkg::IDX_W-1:0];
    wr_id         = rd_id;
    wr_wt         = rd_wt;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          id_nxt     = in_ch.data.target_id;
          draw_nxt   = in_ch.data.draw;
          mask_nxt   = in_ch.data.health_mask;
          cur_nxt    = in_ch.data.cursor_in;
          status_nxt = whbp_pkg::ST_OK;
          pid_nxt    = '0;
          pslot_nxt  = '0;
          idx_nxt    = '0;
          acc_nxt    = '0;
          state_nxt  = S_OUT;
          unique case (in_ch.data.operation)
            whbp_pkg::OP_ADD: begin
              if (in_ch.data.target_id == '0) begin
                status_nxt = whbp_pkg::ST_NULL;
              end else if (int'(used_r) >= whbp_pkg::MAX_ENTRIES) begin
                status_nxt = whbp_pkg::ST_FULL;
              end else begin
                wr_en    = 1'b1;
                wr_idx   = used_r[whbp_pkg::IDX_W-1:0];
                wr_id    = in_ch.data.target_id;
                wr_wt    = whbp_pkg::WEIGHT_BITS'(in_ch.data.entry_weight);
                used_nxt = used_r + 1'b1;
                wsum_nxt = wsum_r + whbp_pkg::SUM_W'(wr_wt);
              end
            end
            whbp_pkg::OP_REMOVE: begin
              if (in_ch.data.target_id == '0) begin
                status_nxt = whbp_pkg::ST_NULL;
              end else begin
                state_nxt = S_FIND;
              end
            end
            whbp_pkg::OP_PICK: begin
              state_nxt = S_SUM;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_FIND: begin
        if (idx_r == used_r) begin
          status_nxt = whbp_pkg::ST_ABSENT;
          state_nxt  = S_OUT;
        end else if (rd_id == id_r) begin
          found_nxt = idx_r[whbp_pkg::IDX_W-1:0];
          wsum_nxt  = wsum_r - whbp_pkg::SUM_W'(rd_wt);
          state_nxt = S_SHIFT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SHIFT: begin
        if (int'(idx_r) + 1 < int'(used_r)) begin
          wr_en   = 1'b1;
          idx_nxt = idx_r + 1'b1;
        end else begin
          used_nxt  = n_after;
          cur_nxt   = cur_adj;
          state_nxt = S_OUT;
        end
      end
      S_SUM: begin
        if (idx_r == used_r) begin
          if (acc_r == '0) begin
            status_nxt = whbp_pkg::ST_NULL;
            state_nxt  = S_OUT;
          end else begin
            tot_nxt   = acc_r;
            state_nxt = S_MUL;
          end
        end else begin
          if (healthy) begin
            acc_nxt = add_res;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_MUL: begin
        target_nxt = whbp_pkg::TOT_W'(prod >> whbp_pkg::DRAW_W);
        acc_nxt    = '0;
        idx_nxt    = '0;
        state_nxt  = S_SEL;
      end
      S_SEL: begin
        if (idx_r == used_r) begin
          status_nxt = whbp_pkg::ST_NULL;
          state_nxt  = S_OUT;
        end else begin
          if (healthy) begin
            acc_nxt = add_res;
            if (target_r < add_res) begin
              pid_nxt   = rd_id;
              pslot_nxt = whbp_pkg::SLOT_W'(idx_r);
              state_nxt = S_OUT;
            end
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.status         = status_r;
          out_data_nxt.picked_id      = pid_r;
          out_data_nxt.picked_slot    = pslot_r;
          out_data_nxt.cursor_out     = cur_r;
          out_data_nxt.entry_total    = whbp_pkg::CUR_W'(used_r);
          out_data_nxt.sum_of_weights = wsum_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      wsum_r      <= wsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    acc_r      <= acc_nxt;
    tot_r      <= tot_nxt;
    target_r   <= target_nxt;
    id_r       <= id_nxt;
    draw_r     <= draw_nxt;
    mask_r     <= mask_nxt;
    cur_r      <= cur_nxt;
    status_r   <= status_nxt;
    pid_r      <= pid_nxt;
    pslot_r    <= pslot_nxt;
    out_data_r <= out_data_nxt;
    if (wr_en) begin
      id_mem_r[wr_idx] <= wr_id;
      wt_mem_r[wr_idx] <= wr_wt;
    end
  end

  // The entry count never passes the table size.
  `WHBP_ASSERT_NOW(a_count_bound, 1'b1, int'(used_r) <= whbp_pkg::MAX_ENTRIES,
                   "entry count exceeds table size")

  // The shift pass only ever runs inside the occupied part of the table.
  `WHBP_ASSERT_NOW(a_shift_range, state_r == S_SHIFT, idx_r < used_r,
                   "shift pass outside occupied slots")

  // A successful pick names an occupied slot.
  `WHBP_ASSERT_NOW(a_pick_slot, out_valid_r && out_data_r.picked_id != '0,
                   int'(out_data_r.picked_slot) < int'(out_data_r.entry_total),
                   "picked slot beyond entry count")

  // A result waiting at the output is loaded only from the final state.
  `WHBP_ASSERT_NEXT(a_out_from_final, !out_valid_r && state_r != S_OUT, !out_valid_r,
                    "result appeared without finishing an item")

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Operation code 3 has no meaning; the block must leave its state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A pick walks the table twice with a multiply step in between, the longest
  // path that any single item can take inside the block.
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 1000;

  logic clk;
  logic rst_n;

  whbp_in_if  in_ch();
  whbp_out_if out_ch();

  weighted_healthy_backend_picker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Our own copy of the backend table, updated at every accepted transfer.
  logic [whbp_pkg::ID_W-1:0]        slot_id [whbp_pkg::MAX_ENTRIES];
  logic [whbp_pkg::WEIGHT_BITS-1:0] slot_wt [whbp_pkg::MAX_ENTRIES];
  int unsigned                      slot_count;
  logic [whbp_pkg::SUM_W-1:0]       weight_total = '0;

  whbp_pkg::out_item_t expected_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int missing;
  int items_sent;
  int results_checked;
  int cycle_count;

  // Tallies of interesting outcomes, printed in the closing summary.
  int n_picked;
  int n_no_pick;
  int n_full;
  int n_absent;
  int n_removed;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Works out the result of one operation and applies it to the shadow table.
  function automatic whbp_pkg::out_item_t predict_result(input whbp_pkg::in_item_t it);
    whbp_pkg::out_item_t r;
    int unsigned u;
    int unsigned n;
    int unsigned cur;
    int unsigned healthy_sum;
    int unsigned run_sum;
    logic [47:0] scaled;
    r = '0;
    r.status = whbp_pkg::ST_OK;
    cur = 32'(it.cursor_in);
    case (it.operation)
      whbp_pkg::OP_ADD: begin
        if (it.target_id == '0) begin
          r.status = whbp_pkg::ST_NULL;
        end else if (slot_count >= whbp_pkg::MAX_ENTRIES) begin
          r.status = whbp_pkg::ST_FULL;
          n_full++;
        end else begin
          slot_id[slot_count] = it.target_id;
          slot_wt[slot_count] = it.entry_weight[whbp_pkg::WEIGHT_BITS-1:0];
          slot_count++;
          weight_total = weight_total +
                         whbp_pkg::SUM_W'(it.entry_weight[whbp_pkg::WEIGHT_BITS-1:0]);
        end
      end
      whbp_pkg::OP_REMOVE: begin
        if (it.target_id == '0) begin
          r.status = whbp_pkg::ST_NULL;
        end else begin
          u = 0;
          while (u < slot_count && slot_id[u] != it.target_id) u++;
          if (u == slot_count) begin
            r.status = whbp_pkg::ST_ABSENT;
            n_absent++;
          end else begin
            weight_total = weight_total - whbp_pkg::SUM_W'(slot_wt[u]);
            for (n = u; n + 1 < slot_count; n++) begin
              slot_id[n] = slot_id[n + 1];
              slot_wt[n] = slot_wt[n + 1];
            end
            slot_count--;
            // The caller's cursor follows its entry down; a cursor that now
            // points past the end wraps back to the first slot.
            if (u < cur) begin
              cur--;
            end else if (cur == slot_count) begin
              cur = 0;
            end
            if (cur > slot_count) cur = 0;
            n_removed++;
          end
        end
      end
      whbp_pkg::OP_PICK: begin
        healthy_sum = 0;
        for (u = 0; u < slot_count; u++) begin
          if (u < whbp_pkg::HEALTH_W && it.health_mask[u]) begin
            healthy_sum += 32'(slot_wt[u]);
          end
        end
        r.status = whbp_pkg::ST_NULL;
        if (healthy_sum != 0) begin
          scaled = 48'(it.draw) * 48'(healthy_sum);
          run_sum = 0;
          for (u = 0; u < slot_count; u++) begin
            if (u < whbp_pkg::HEALTH_W && it.health_mask[u]) begin
              run_sum += 32'(slot_wt[u]);
              if ((scaled >> 16) < 48'(run_sum)) begin
                r.status      = whbp_pkg::ST_OK;
                r.picked_id   = slot_id[u];
                r.picked_slot = whbp_pkg::SLOT_W'(u);
                break;
              end
            end
          end
        end
        if (r.status == whbp_pkg::ST_OK) n_picked++;
        else n_no_pick++;
      end
      default: begin
      end
    endcase
    r.cursor_out     = whbp_pkg::CUR_W'(cur);
    r.entry_total    = whbp_pkg::CUR_W'(slot_count);
    r.sum_of_weights = weight_total;
    return r;
  endfunction

  task automatic note_failure(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    end
  endtask

  // Every transfer on either channel is observed here at the clock edge. A
  // result is checked against the oldest prediction before the input side is
  // folded in; a result can never belong to an item accepted at the same edge.
  always @(posedge clk) begin : result_check
    whbp_pkg::out_item_t want;
    whbp_pkg::out_item_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        results_checked++;
        if (expected_q.size() == 0) begin
          note_failure("unexpected result, status", '0, 32'(got.status));
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status)
            note_failure("status", 32'(want.status), 32'(got.status));
          if (got.picked_id !== want.picked_id)
            note_failure("picked_id", 32'(want.picked_id), 32'(got.picked_id));
          if (got.picked_slot !== want.picked_slot)
            note_failure("picked_slot", 32'(want.picked_slot), 32'(got.picked_slot));
          if (got.cursor_out !== want.cursor_out)
            note_failure("cursor_out", 32'(want.cursor_out), 32'(got.cursor_out));
          if (got.entry_total !== want.entry_total)
            note_failure("entry_total", 32'(want.entry_total), 32'(got.entry_total));
          if (got.sum_of_weights !== want.sum_of_weights)
            note_failure("sum_of_weights", 32'(want.sum_of_weights),
                         32'(got.sum_of_weights));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(predict_result(in_ch.data));
      end
    end
  end

  // The result side stalls at random according to the current idling phase.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, expected_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  function automatic whbp_pkg::in_item_t make_item(input logic [1:0] op,
                                                   input logic [15:0] id,
                                                   input logic [15:0] wt,
                                                   input logic [15:0] draw,
                                                   input logic [15:0] mask,
                                                   input logic [4:0] cur);
    whbp_pkg::in_item_t it;
    it.operation    = op;
    it.target_id    = id;
    it.entry_weight = wt;
    it.draw         = draw;
    it.health_mask  = mask;
    it.cursor_in    = cur;
    return it;
  endfunction

  // Presents one item and holds it until the transfer happens. Valid is only
  // lowered when the sender decides to idle, so back-to-back items never see
  // valid dropped and raised within the same time step.
  task automatic send_item(input whbp_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back. The
  // first edge lets the monitor record the last transfer before the queue is
  // looked at.
  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // Operations on an empty table, the null id and the unused operation code.
  task automatic test_empty_table();
    send_item(make_item(whbp_pkg::OP_PICK, 16'h0000, 16'h0000, 16'h8000, 16'hFFFF, 5'd0));
    send_item(make_item(whbp_pkg::OP_REMOVE, 16'h0005, 16'h0000, 16'h0000, 16'h0000, 5'd3));
    send_item(make_item(whbp_pkg::OP_ADD, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 5'd16));
    send_item(make_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31));
    send_item(make_item(whbp_pkg::OP_REMOVE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 5'd1));
  endtask

  // Fills all sixteen slots, including the widest id and weight and a zero
  // weight, then adds once more to a full table.
  task automatic test_fill_to_capacity();
    send_item(make_item(whbp_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 5'd0));
    send_item(make_item(whbp_pkg::OP_ADD, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 5'd0));
    for (int i = 2; i < whbp_pkg::MAX_ENTRIES; i++) begin
      send_item(make_item(whbp_pkg::OP_ADD, 16'(i), 16'($urandom_range(1, 16'hFFFF)),
                          16'h0000, 16'h0000, 5'd0));
    end
    send_item(make_item(whbp_pkg::OP_ADD, 16'h8000, 16'h1234, 16'h0000, 16'h0000, 5'd0));
  endtask

  // Picks at both ends of the draw range, with no healthy slot, with only a
  // zero-weight slot healthy, and with only the last slot healthy.
  task automatic test_pick_edges();
    send_item(make_item(whbp_pkg::OP_PICK, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 5'd2));
    send_item(make_item(whbp_pkg::OP_PICK, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 5'd2));
    send_item(make_item(whbp_pkg::OP_PICK, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 5'd2));
    send_item(make_item(whbp_pkg::OP_PICK, 16'h0000, 16'h0000, 16'h4000, 16'h0002, 5'd2));
    send_item(make_item(whbp_pkg::OP_PICK, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 5'd2));
  endtask

  // Removes from the front, from the end and from the middle, so that the
  // cursor is decremented, reset when it equals the new count, and wrapped
  // when it lies beyond the table.
  task automatic test_remove_and_cursor();
    send_item(make_item(whbp_pkg::OP_REMOVE, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 5'd5));
    send_item(make_item(whbp_pkg::OP_REMOVE, 16'h000F, 16'h0000, 16'h0000, 16'h0000, 5'd14));
    send_item(make_item(whbp_pkg::OP_REMOVE, 16'h0007, 16'h0000, 16'h0000, 16'h0000, 5'd31));
  endtask

  // Random traffic. Ids come mostly from a small pool, and removes mostly
  // name an id that sits in the table, so entries come and go; the operation
  // mix swings between filling and draining so that the table spends time
  // both near empty and full.
  function automatic whbp_pkg::in_item_t random_item(input bit fill_bias);
    whbp_pkg::in_item_t it;
    int                 r;
    r = $urandom_range(99);
    if (fill_bias) begin
      it.operation = (r < 55) ? whbp_pkg::OP_ADD :
                     (r < 70) ? whbp_pkg::OP_REMOVE :
                     (r < 98) ? whbp_pkg::OP_PICK : OP_UNUSED;
    end else begin
      it.operation = (r < 20) ? whbp_pkg::OP_ADD :
                     (r < 60) ? whbp_pkg::OP_REMOVE :
                     (r < 98) ? whbp_pkg::OP_PICK : OP_UNUSED;
    end
    r = $urandom_range(99);
    if (r < 4) it.target_id = 16'h0000;
    else if (r < 8) it.target_id = 16'hFFFF;
    else if (r < 85) it.target_id = 16'($urandom_range(1, 40));
    else it.target_id = 16'($urandom);
    if (it.operation == whbp_pkg::OP_REMOVE && slot_count > 0 && $urandom_range(99) < 70) begin
      it.target_id = slot_id[$urandom_range(slot_count - 1)];
    end
    case ($urandom_range(9))
      0:       it.entry_weight = 16'h0000;
      1:       it.entry_weight = 16'hFFFF;
      2, 3, 4: it.entry_weight = 16'($urandom_range(1, 15));
      default: it.entry_weight = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0:       it.health_mask = 16'h0000;
      1:       it.health_mask = 16'hFFFF;
      2:       it.health_mask = 16'h0001 << $urandom_range(15);
      default: it.health_mask = 16'($urandom);
    endcase
    case ($urandom_range(7))
      0:       it.draw = 16'h0000;
      1:       it.draw = 16'hFFFF;
      default: it.draw = 16'($urandom);
    endcase
    it.cursor_in = ($urandom_range(99) < 85) ? 5'($urandom_range(16)) : 5'($urandom_range(31));
    return it;
  endfunction

  task automatic test_random_traffic(input int n_items);
    for (int i = 0; i < n_items; i++) begin
      // Now and then the sender holds off until the block has gone quiet.
      if (i % 150 == 75) wait_until_drained();
      send_item(random_item(((i / 60) % 2) == 0));
    end
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    items_sent    = 0;
    send_idle_pct = 33;
    recv_idle_pct = 80;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles now and then, receiver stalls most cycles.
    test_empty_table();
    test_fill_to_capacity();
    test_pick_edges();
    test_remove_and_cursor();
    test_random_traffic(RANDOM_ITEMS / 3);

    // Phase two: the other way round.
    send_idle_pct = 80;
    recv_idle_pct = 33;
    test_random_traffic(RANDOM_ITEMS / 3);

    // Phase three: both sides at full rate.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    missing = expected_q.size();
    if (missing != 0) begin
      $display("%0d predicted results never arrived", missing);
    end

    $display("summary: %0d operations sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, error_count + missing);
    $display("summary: %0d picks made, %0d with nothing to pick, %0d removes, %0d absent, %0d full",
             n_picked, n_no_pick, n_removed, n_absent, n_full);
    if (error_count == 0 && missing == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
